// ===== sv/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Opcodes, widths and the per-stage record carried down the cell chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int DATA_W     = 32;
   localparam int KIND_W     = 4;
   localparam int NUM_W      = DATA_W + FRAC_BITS;   // scaled dividend width
   localparam int DIV_STAGES = NUM_W;                // one quotient bit per cell

   localparam logic [KIND_W-1:0] OP_ADD = 4'd0;
   localparam logic [KIND_W-1:0] OP_SUB = 4'd1;
   localparam logic [KIND_W-1:0] OP_MUL = 4'd2;
   localparam logic [KIND_W-1:0] OP_DIV = 4'd3;
   localparam logic [KIND_W-1:0] OP_GT  = 4'd4;
   localparam logic [KIND_W-1:0] OP_LT  = 4'd5;
   localparam logic [KIND_W-1:0] OP_GE  = 4'd6;
   localparam logic [KIND_W-1:0] OP_LE  = 4'd7;
   localparam logic [KIND_W-1:0] OP_EQ  = 4'd8;
   localparam logic [KIND_W-1:0] OP_NE  = 4'd9;
   localparam logic [KIND_W-1:0] OP_MAX = 4'd10;
   localparam logic [KIND_W-1:0] OP_MIN = 4'd11;
   localparam logic [KIND_W-1:0] OP_INC = 4'd12;
   localparam logic [KIND_W-1:0] OP_DEC = 4'd13;
   localparam logic [KIND_W-1:0] OP_TOI = 4'd14;
   localparam logic [KIND_W-1:0] OP_FRI = 4'd15;

   // record handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              neg;       // quotient sign
      logic              dz;
      logic [NUM_W-1:0]  num;       // dividend bits, shifted out msb first
      logic [DATA_W-1:0] den;       // |divisor|
      logic [DATA_W:0]   rem;       // partial remainder
      logic [DATA_W-1:0] quo;       // low quotient bits
      logic [DATA_W-1:0] res;       // finished result for non-divide requests
      logic              cmp;
   } stage_type;

endpackage

// ===== sv/fpa_cell.sv =====
// ----------------------------------------------------------------------------
// fpa_cell: one restoring-division step
// Consumes one dividend bit, forms one quotient bit, registers the record.
// ----------------------------------------------------------------------------
module fpa_cell (
   input  logic               clock,
   input  logic               reset,
   input  fpa_pkg::stage_type stage_in,
   output fpa_pkg::stage_type stage_out
);

   fpa_pkg::stage_type stage_ff;
   fpa_pkg::stage_type stage_in_w;
   logic [fpa_pkg::DATA_W+1:0] trial;
   logic [fpa_pkg::DATA_W+1:0] shifted;

   always_comb begin
      stage_in_w = stage_in;
      shifted = {stage_in.rem, stage_in.num[fpa_pkg::NUM_W-1]};
      trial = shifted - {2'b00, stage_in.den};
      stage_in_w.num = {stage_in.num[fpa_pkg::NUM_W-2:0], 1'b0};
      if (!trial[fpa_pkg::DATA_W+1]) begin
         stage_in_w.rem = trial[fpa_pkg::DATA_W:0];
         stage_in_w.quo = {stage_in.quo[fpa_pkg::DATA_W-2:0], 1'b1};
      end else begin
         stage_in_w.rem = shifted[fpa_pkg::DATA_W:0];
         stage_in_w.quo = {stage_in.quo[fpa_pkg::DATA_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== sv/fpa_front.sv =====
// ----------------------------------------------------------------------------
// fpa_front: operand decode stage
// Does the non-divide operations and seeds the division chain.
// ----------------------------------------------------------------------------
module fpa_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [fpa_pkg::KIND_W-1:0]        kind,
   input  logic signed [fpa_pkg::DATA_W-1:0] op_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] op_b,
   output fpa_pkg::stage_type                stage_out
);

   localparam int W = fpa_pkg::DATA_W;
   localparam int F = fpa_pkg::FRAC_BITS;

   fpa_pkg::stage_type stage_ff;
   fpa_pkg::stage_type stage_in;
   logic signed [2*W-1:0] prod;
   logic [W-1:0] abs_a;
   logic [W-1:0] abs_b;
   logic gt;
   logic lt;

   // signed 32x32 product, full 64 bits
   assign prod  = (2*W)'(op_a) * (2*W)'(op_b);
   assign abs_a = op_a[W-1] ? W'(-op_a) : op_a;
   assign abs_b = op_b[W-1] ? W'(-op_b) : op_b;
   assign gt    = op_a > op_b;
   assign lt    = op_a < op_b;

   always_comb begin
      stage_in = '0;
      stage_in.valid  = accept;
      stage_in.is_div = (kind == fpa_pkg::OP_DIV);
      stage_in.dz     = (kind == fpa_pkg::OP_DIV) && (op_b == '0);
      stage_in.neg    = op_a[W-1] ^ op_b[W-1];
      stage_in.num    = {abs_a, {F{1'b0}}};
      stage_in.den    = abs_b;
      unique case (kind)
         fpa_pkg::OP_ADD: stage_in.res = op_a + op_b;
         fpa_pkg::OP_SUB: stage_in.res = op_a - op_b;
         fpa_pkg::OP_MUL: stage_in.res = prod[W+F-1:F];
         fpa_pkg::OP_DIV: stage_in.res = '0;
         fpa_pkg::OP_GT:  stage_in.cmp = gt;
         fpa_pkg::OP_LT:  stage_in.cmp = lt;
         fpa_pkg::OP_GE:  stage_in.cmp = !lt;
         fpa_pkg::OP_LE:  stage_in.cmp = !gt;
         fpa_pkg::OP_EQ:  stage_in.cmp = (op_a == op_b);
         fpa_pkg::OP_NE:  stage_in.cmp = (op_a != op_b);
         fpa_pkg::OP_MAX: stage_in.res = gt ? op_a : op_b;
         fpa_pkg::OP_MIN: stage_in.res = lt ? op_a : op_b;
         fpa_pkg::OP_INC: stage_in.res = op_a + W'(1);
         fpa_pkg::OP_DEC: stage_in.res = op_a - W'(1);
         fpa_pkg::OP_TOI: stage_in.res = W'(op_a >>> F);
         default:         stage_in.res = {op_a[W-F-1:0], {F{1'b0}}};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== sv/fixed_point_alu_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_core: signed Q-format fixed-point ALU
// Decode stage, a chain of division cells, and a registered result stage.
// ----------------------------------------------------------------------------
// A request is taken every clock cycle (busy is always low). Every request,
// whatever its opcode, travels the same pipeline: one decode stage, one
// cell per scaled-dividend bit (DATA_W + FRAC_BITS cells, 40 at Q24.8), and
// one output stage, so results leave in the order their requests came in.
// The result is on the rsp_ ports for one cycle with rsp_valid high; the
// receiver cannot stall it.
module fixed_point_alu_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [fpa_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                              rsp_valid,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_result_raw,
   output logic                              rsp_compare_true,
   output logic                              rsp_divide_by_zero
);

   localparam int N = fpa_pkg::DIV_STAGES;
   localparam int W = fpa_pkg::DATA_W;

   fpa_pkg::stage_type chain [N+1];
   logic              valid_ff;
   logic [W-1:0]      result_ff;
   logic              cmp_ff;
   logic              dz_ff;
   logic [W-1:0]      result_in;

   assign busy = 1'b0;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (start),
      .kind      (req_kind),
      .op_a      (req_operand_a),
      .op_b      (req_operand_b),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      fpa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // quotient sign fix-up; divide by zero leaves zero
   always_comb begin
      if (chain[N].is_div) begin
         if (chain[N].dz) begin
            result_in = '0;
         end else if (chain[N].neg) begin
            result_in = W'(-chain[N].quo);
         end else begin
            result_in = chain[N].quo;
         end
      end else begin
         result_in = chain[N].res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= chain[N].valid;
      end
      result_ff <= result_in;
      cmp_ff    <= chain[N].cmp;
      dz_ff     <= chain[N].dz;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_raw     = result_ff;
   assign rsp_compare_true   = cmp_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule
